[rtl/qfs_pkg.sv]
// Package: internal fixed-point format, constants and arithmetic helpers for the slerp block.
package qfs_pkg;

  localparam int IBITS = 24;
  localparam int IW    = 32;

  typedef logic signed [IW-1:0] ival_t;

  localparam ival_t ILIM        = 32'sd2147483647;
  localparam ival_t IONE        = 32'sd16777216;
  localparam ival_t K_A0        = 32'sd18287165;
  localparam ival_t K_A1        = 32'sd7994964;
  localparam ival_t K_A2        = 32'sd1515521;
  localparam ival_t K_S0        = 32'sd740;
  localparam ival_t K_S1        = -32'sd26631;
  localparam ival_t K_S2        = 32'sd559241;
  localparam ival_t K_S3        = -32'sd5592405;
  localparam ival_t K_HALF      = 32'sd8388608;
  localparam ival_t K_THREEHALF = 32'sd25165824;
  localparam ival_t K_FOUR      = 32'sd67108864;
  localparam ival_t K_NINE      = 32'sd150994944;
  localparam ival_t K_SIXTEEN   = 32'sd268435456;

  // Saturate a wide signed value to +-(2^31-1).
  function automatic ival_t sat64(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return ILIM;
    end else if (v < -66'sd2147483647) begin
      return -ILIM;
    end
    return ival_t'(v[IW-1:0]);
  endfunction

  function automatic ival_t add(input ival_t a, input ival_t b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    return sat64(s);
  endfunction

  // Q.24 product, half-up rounding (arithmetic shift after bias is floor).
  function automatic ival_t mul(input ival_t a, input ival_t b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd8388608;
    return sat64(p >>> IBITS);
  endfunction

  function automatic ival_t absv(input ival_t a);
    return a[IW-1] ? -a : a;
  endfunction

endpackage

[rtl/quaternion_fast_slerp.sv]
// Top level: pipelined fixed-point quaternion slerp with stream ports.
// Pipeline: 27 register stages between the accepted input word and its result word.
// Throughput: one word per cycle; a single global enable stalls every stage
// together when the output is not taken, so nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data regs keep no reset.
module quaternion_fast_slerp #(
  parameter int COMPONENT_WIDTH = 18,
  parameter int FRACTION_BITS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: first_x, first_y, first_z, first_w, second_x, second_y, second_z,
  // second_w, blend (lowest bits first), zero padded
  input  logic [((8*COMPONENT_WIDTH+FRACTION_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: out_x, out_y, out_z, out_w (lowest bits first), zero padded
  output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  localparam int CW    = COMPONENT_WIDTH;
  localparam int TW    = FRACTION_BITS + 1;
  localparam int NST   = 27;
  localparam int OWL   = ((4*CW+7)/8)*8;
  localparam int SH    = qfs_pkg::IBITS - FRACTION_BITS;
  localparam int VW    = ((CW > TW) ? CW : TW) + 1;

  typedef qfs_pkg::ival_t iv_t;
  typedef iv_t [3:0] quad_t;

  // Global enable: advance when the output slot is free or being taken.
  logic en;
  logic [NST-1:0] vld_q;
  assign en = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Convert an input value (sign- or zero-extended) into Q.24.
  function automatic iv_t to_int(input logic signed [VW-1:0] v);
    logic signed [65:0] w;
    w = 66'(v);
    if (SH > 0) begin
      return qfs_pkg::sat64(w <<< SH);
    end else if (SH < 0) begin
      return qfs_pkg::sat64((w + (66'sd1 <<< (-SH-1))) >>> (-SH));
    end
    return qfs_pkg::sat64(w);
  endfunction

  function automatic logic [CW-1:0] from_int(input iv_t v);
    logic signed [65:0] r;
    logic signed [65:0] hi;
    r = 66'(v);
    hi = (66'sd1 <<< (CW-1)) - 66'sd1;
    if (SH < 0) begin
      r = r <<< (-SH);
    end else if (SH > 0) begin
      r = (r + (66'sd1 <<< (SH-1))) >>> SH;
    end
    if (r > hi) begin
      r = hi;
    end else if (r < -hi - 66'sd1) begin
      r = -hi - 66'sd1;
    end
    return r[CW-1:0];
  endfunction

  // Per-stage payload, shifted along with the valid bits.
  typedef struct packed {
    logic [1:0]          mode;   // 0 compute, 1 pass first, 2 pass second
    logic [4*CW-1:0]     ra;     // raw first quaternion
    logic [4*CW-1:0]     rb;     // raw second quaternion
    quad_t               a;
    quad_t               b;
  } ctl_t;

  localparam logic [1:0] M_CALC = 2'd0;
  localparam logic [1:0] M_FST  = 2'd1;
  localparam logic [1:0] M_SND  = 2'd2;

  ctl_t ctl_q [NST];

  // Stage 0: unpack, early-exit decode, format conversion.
  ctl_t c0;
  iv_t  t0;
  always_comb begin
    logic [TW-1:0] tr;
    logic same;
    c0.ra = s_axis_tdata[4*CW-1:0];
    c0.rb = s_axis_tdata[8*CW-1:4*CW];
    tr    = s_axis_tdata[8*CW+TW-1:8*CW];
    same  = (c0.ra == c0.rb);
    if (tr == '0 || same) begin
      c0.mode = M_FST;
    end else if (tr[TW-1]) begin
      c0.mode = M_SND;
    end else begin
      c0.mode = M_CALC;
    end
    for (int i = 0; i < 4; i++) begin
      c0.a[i] = to_int(VW'(signed'(c0.ra[i*CW +: CW])));
      c0.b[i] = to_int(VW'(signed'(c0.rb[i*CW +: CW])));
    end
    t0 = to_int(VW'(tr));
  end

  // Scalar datapath registers per stage.
  iv_t t1_q, pr_q [4], s2a_q, s2b_q, cos_q, hy_q;
  iv_t f2b_q, u_q, f2a_q, u2_q;
  iv_t g1_q, g2_q, h_q, hh_q, hhh_q, h2_q, c_q;
  iv_t w1_q, w2_q, hs_q;
  iv_t f1b_q, f2ab_q, f2bb_q, al_q, be_q;
  iv_t len01_q, len23_q, len_q, corr_q;
  iv_t r_w [4], sq_w [4];
  iv_t rr_q [4], r2_q [4], r3_q [4];
  logic [4*CW-1:0] od;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= c0;
      for (int k = 1; k < NST; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
      // S1: partial products of the dot.
      t1_q <= t0;
      for (int i = 0; i < 4; i++) begin
        pr_q[i] <= qfs_pkg::mul(c0.a[i], c0.b[i]);
      end
      // S2: dot product w+x+y+z, saturated once.
      s2a_q <= iv_t'(qfs_pkg::sat64(66'(pr_q[3]) + 66'(pr_q[0]) + 66'(pr_q[1])
                                   + 66'(pr_q[2])));
      f2b_q <= qfs_pkg::add(t1_q, -qfs_pkg::K_HALF);
      // S3: |cos|, half-y; t folding.
      cos_q <= s2a_q;
      hy_q  <= qfs_pkg::add(qfs_pkg::IONE, qfs_pkg::absv(s2a_q));
      u_q   <= qfs_pkg::absv(f2b_q);
      s2b_q <= f2b_q;
      // S4: t folding finish; first Newton term.
      f2a_q <= qfs_pkg::add(u_q, -s2b_q);
      f2bb_q <= qfs_pkg::add(s2b_q, u_q);
      u2_q  <= qfs_pkg::add(u_q, u_q);
      g1_q  <= qfs_pkg::mul(qfs_pkg::K_A2, hy_q);
      hh_q  <= hy_q;
    end
  end

  // The remaining stages: carried in a second block for readability.
  // Carry line entry k holds the value of stage 5+k.
  iv_t hy5_q, hy6_q, hy7_q, hy8_q, hy9_q, hy10_q;
  iv_t f2a5_q [15], f2b5_q [15], u5_q [7], f15_q [16];
  logic negc_q [17];
  logic negc4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      negc4_q <= cos_q[qfs_pkg::IW-1];
      // S5
      hy5_q   <= hh_q;
      g2_q    <= qfs_pkg::add(qfs_pkg::K_A1, -g1_q);
      f2a5_q[0] <= f2a_q;
      f2b5_q[0] <= f2bb_q;
      u5_q[0]   <= u2_q;
      f15_q[0]  <= qfs_pkg::add(qfs_pkg::IONE, -u2_q);
      negc_q[0] <= negc4_q;
      for (int k = 1; k < 15; k++) begin
        f2a5_q[k] <= f2a5_q[k-1];
        f2b5_q[k] <= f2b5_q[k-1];
      end
      for (int k = 1; k < 7; k++) begin
        u5_q[k] <= u5_q[k-1];
      end
      for (int k = 1; k < 16; k++) begin
        f15_q[k] <= f15_q[k-1];
      end
      for (int k = 1; k < 17; k++) begin
        negc_q[k] <= negc_q[k-1];
      end
      // S6: h0
      hy6_q <= hy5_q;
      h_q   <= qfs_pkg::add(qfs_pkg::K_A0, -qfs_pkg::mul(g2_q, hy5_q));
      // S7: halfy*h
      hy7_q <= hy6_q;
      h2_q  <= h_q;
      hhh_q <= qfs_pkg::mul(hy6_q, h_q);
      // S8: *h
      hy8_q <= hy7_q;
      hs_q  <= h2_q;
      w1_q  <= qfs_pkg::mul(hhh_q, h2_q);
      // S9: newton
      hy9_q <= hy8_q;
      w2_q  <= qfs_pkg::mul(hs_q, qfs_pkg::add(qfs_pkg::K_THREEHALF, -w1_q));
      // S10: vers
      hy10_q <= qfs_pkg::mul(hy9_q, w2_q);
      c_q    <= w2_q;   // h
    end
  end

  // S11..: vers, c, squares, series. Named by stage.
  iv_t h11_q, v11_q, h12_q, v12_q, c12_q, sq1_12_q, sq2_12_q;
  iv_t hx_q [7];
  iv_t vx_q [6];
  iv_t sf_q [5], su_q [5];   // squares carried
  iv_t ra_q [9], rb_q [9];   // series accumulators

  always_ff @(posedge clk_i) begin
    if (en) begin
      // S11
      h11_q <= c_q;
      v11_q <= qfs_pkg::add(qfs_pkg::IONE, -hy10_q);
      // S12: c, squares (f1 and u from entry 6 of the carry line)
      h12_q <= h11_q;
      v12_q <= v11_q;
      c12_q <= qfs_pkg::mul(qfs_pkg::K_S0, v11_q);
      sq1_12_q <= qfs_pkg::mul(f15_q[6], f15_q[6]);
      sq2_12_q <= qfs_pkg::mul(u5_q[6], u5_q[6]);
      // S13: r = S1 + (sq-16)*c
      hx_q[0] <= h12_q;
      vx_q[0] <= v12_q;
      sf_q[0] <= sq1_12_q;
      su_q[0] <= sq2_12_q;
      ra_q[0] <= qfs_pkg::add(qfs_pkg::K_S1,
                   qfs_pkg::mul(qfs_pkg::add(sq1_12_q, -qfs_pkg::K_SIXTEEN), c12_q));
      rb_q[0] <= qfs_pkg::add(qfs_pkg::K_S1,
                   qfs_pkg::mul(qfs_pkg::add(sq2_12_q, -qfs_pkg::K_SIXTEEN), c12_q));
      for (int k = 1; k < 7; k++) begin
        hx_q[k] <= hx_q[k-1];
      end
      for (int k = 1; k < 6; k++) begin
        vx_q[k] <= vx_q[k-1];
      end
      for (int k = 1; k < 5; k++) begin
        sf_q[k] <= sf_q[k-1];
        su_q[k] <= su_q[k-1];
      end
      // S14: r*(sq-9)
      ra_q[1] <= qfs_pkg::mul(ra_q[0], qfs_pkg::add(sf_q[0], -qfs_pkg::K_NINE));
      rb_q[1] <= qfs_pkg::mul(rb_q[0], qfs_pkg::add(su_q[0], -qfs_pkg::K_NINE));
      // S15: S2 + *vers
      ra_q[2] <= qfs_pkg::add(qfs_pkg::K_S2, qfs_pkg::mul(ra_q[1], vx_q[1]));
      rb_q[2] <= qfs_pkg::add(qfs_pkg::K_S2, qfs_pkg::mul(rb_q[1], vx_q[1]));
      // S16: *(sq-4)
      ra_q[3] <= qfs_pkg::mul(ra_q[2], qfs_pkg::add(sf_q[2], -qfs_pkg::K_FOUR));
      rb_q[3] <= qfs_pkg::mul(rb_q[2], qfs_pkg::add(su_q[2], -qfs_pkg::K_FOUR));
      // S17: S3 + *vers
      ra_q[4] <= qfs_pkg::add(qfs_pkg::K_S3, qfs_pkg::mul(ra_q[3], vx_q[3]));
      rb_q[4] <= qfs_pkg::add(qfs_pkg::K_S3, qfs_pkg::mul(rb_q[3], vx_q[3]));
      // S18: *(sq-1)
      ra_q[5] <= qfs_pkg::mul(ra_q[4], qfs_pkg::add(sf_q[4], -qfs_pkg::IONE));
      rb_q[5] <= qfs_pkg::mul(rb_q[4], qfs_pkg::add(su_q[4], -qfs_pkg::IONE));
      // S19: 1 + *vers -> r1, r2
      ra_q[6] <= qfs_pkg::add(qfs_pkg::IONE, qfs_pkg::mul(ra_q[5], vx_q[5]));
      rb_q[6] <= qfs_pkg::add(qfs_pkg::IONE, qfs_pkg::mul(rb_q[5], vx_q[5]));
      // S20: r1*h ; f2a*r2 ; f2b*r2
      ra_q[7] <= qfs_pkg::mul(ra_q[6], hx_q[6]);
      f2ab_q  <= qfs_pkg::mul(f2a5_q[14], rb_q[6]);
      rb_q[7] <= qfs_pkg::mul(f2b5_q[14], rb_q[6]);
      // S21: f1 * (r1*h); alpha/beta
      f1b_q   <= qfs_pkg::mul(f15_q[15], ra_q[7]);
      ra_q[8] <= f2ab_q;
      rb_q[8] <= rb_q[7];
      // S22
      al_q <= negc_q[16] ? -qfs_pkg::add(f1b_q, ra_q[8]) : qfs_pkg::add(f1b_q, ra_q[8]);
      be_q <= qfs_pkg::add(f1b_q, rb_q[8]);
    end
  end

  // Stages 23..24: weighted sum per component (two register levels in qfs_lerp).
  for (genvar i = 0; i < 4; i++) begin : g_lane
    qfs_lerp u_lerp (
      .clk_i (clk_i),
      .en_i  (en),
      .al_i  (al_q),
      .be_i  (be_q),
      .a_i   (ctl_q[21].a[i]),
      .b_i   (ctl_q[21].b[i]),
      .r_o   (r_w[i]),
      .sq_o  (sq_w[i])
    );
  end

  // S25..S27: length, correction; components carried alongside.
  always_ff @(posedge clk_i) begin
    if (en) begin
      len01_q <= qfs_pkg::add(qfs_pkg::add(qfs_pkg::add(0, sq_w[0]), sq_w[1]), sq_w[2]);
      len23_q <= sq_w[3];
      for (int i = 0; i < 4; i++) begin
        rr_q[i] <= r_w[i];
        r2_q[i] <= rr_q[i];
      end
      len_q  <= qfs_pkg::add(len01_q, len23_q);
      corr_q <= qfs_pkg::add(qfs_pkg::K_THREEHALF, -qfs_pkg::mul(qfs_pkg::K_HALF, len_q));
      for (int i = 0; i < 4; i++) begin
        r3_q[i] <= r2_q[i];
      end
    end
  end

  // Final stage: scale by the correction, or pass the early-exit quaternion.
  always_comb begin
    od = '0;
    for (int i = 0; i < 4; i++) begin
      od[i*CW +: CW] = from_int(qfs_pkg::mul(r3_q[i], corr_q));
    end
    case (ctl_q[NST-1].mode)
      M_FST:   od = ctl_q[NST-1].ra;
      M_SND:   od = ctl_q[NST-1].rb;
      default: ;
    endcase
  end
  assign m_axis_tdata = OWL'(od);
endmodule

[rtl/qfs_lerp.sv]
// Module: weighted sum alpha*a + beta*b for one component, and its square.
module qfs_lerp (
  input  logic          clk_i,
  input  logic          en_i,
  input  qfs_pkg::ival_t al_i,
  input  qfs_pkg::ival_t be_i,
  input  qfs_pkg::ival_t a_i,
  input  qfs_pkg::ival_t b_i,
  output qfs_pkg::ival_t r_o,
  output qfs_pkg::ival_t sq_o
);
  qfs_pkg::ival_t pa_q, pb_q, r_q, sq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= qfs_pkg::mul(al_i, a_i);
      pb_q <= qfs_pkg::mul(be_i, b_i);
      r_q  <= qfs_pkg::add(pa_q, pb_q);
      sq_q <= qfs_pkg::mul(qfs_pkg::add(pa_q, pb_q), qfs_pkg::add(pa_q, pb_q));
    end
  end

  assign r_o  = r_q;
  assign sq_o = sq_q;
endmodule

[test/tb.sv]
// Testbench for quaternion_fast_slerp: stream stimulus, in-bench slerp predictor, result checks.
`timescale 1ns / 100ps

module tb;
  localparam int CW = 18;
  localparam int FB = 16;
  localparam int IN_W = ((8*CW+FB+1+7)/8)*8;
  localparam int OUT_W = ((4*CW+7)/8)*8;
  localparam int CYCLE_LIMIT = 400000;

  typedef qfs_pkg::ival_t ival_t;
  typedef logic signed [CW-1:0] comp_t;
  typedef struct packed {
    logic [FB:0] blend;
    comp_t sw, sz, sy, sx, fw, fz, fy, fx;
  } pair_t;
  typedef struct packed {
    comp_t w, z, y, x;
  } quat_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;

  quat_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int out_hold = 0;
  bit no_gaps = 0;

  quaternion_fast_slerp dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Rounded conversion from Q.24 back to the component format, saturated.
  function automatic comp_t to_comp(input ival_t v);
    logic signed [65:0] r;
    r = (66'(v) + 66'sd128) >>> (qfs_pkg::IBITS - FB);
    if (r > 66'sd131071) r = 66'sd131071;
    if (r < -66'sd131072) r = -66'sd131072;
    return comp_t'(r);
  endfunction

  function automatic ival_t weight(input ival_t sq, input ival_t c, input ival_t vers);
    ival_t r;
    r = qfs_pkg::add(qfs_pkg::K_S1, qfs_pkg::mul(qfs_pkg::add(sq, -qfs_pkg::K_SIXTEEN), c));
    r = qfs_pkg::add(qfs_pkg::K_S2,
          qfs_pkg::mul(qfs_pkg::mul(r, qfs_pkg::add(sq, -qfs_pkg::K_NINE)), vers));
    r = qfs_pkg::add(qfs_pkg::K_S3,
          qfs_pkg::mul(qfs_pkg::mul(r, qfs_pkg::add(sq, -qfs_pkg::K_FOUR)), vers));
    return qfs_pkg::add(qfs_pkg::IONE,
             qfs_pkg::mul(qfs_pkg::mul(r, qfs_pkg::add(sq, -qfs_pkg::IONE)), vers));
  endfunction

  function automatic quat_t slerp(input pair_t p);
    ival_t a[4], b[4], r[4];
    ival_t cosv, halfy, t, f1, f2a, f2b, u, h, vers, c, r1, r2, al, be, len, corr;
    logic signed [65:0] dot;
    quat_t q;
    a = '{ival_t'(p.fx) <<< 8, ival_t'(p.fy) <<< 8, ival_t'(p.fz) <<< 8, ival_t'(p.fw) <<< 8};
    b = '{ival_t'(p.sx) <<< 8, ival_t'(p.sy) <<< 8, ival_t'(p.sz) <<< 8, ival_t'(p.sw) <<< 8};
    if (p.blend == 0 || {p.fx, p.fy, p.fz, p.fw} == {p.sx, p.sy, p.sz, p.sw})
      return '{w: p.fw, z: p.fz, y: p.fy, x: p.fx};
    if (p.blend[FB]) return '{w: p.sw, z: p.sz, y: p.sy, x: p.sx};
    t = ival_t'({1'b0, p.blend}) <<< 8;
    // dot product: plain sum of four products, saturated once
    dot = 66'(qfs_pkg::mul(a[3], b[3])) + 66'(qfs_pkg::mul(a[0], b[0]))
        + 66'(qfs_pkg::mul(a[1], b[1])) + 66'(qfs_pkg::mul(a[2], b[2]));
    cosv = qfs_pkg::sat64(dot);
    halfy = qfs_pkg::add(qfs_pkg::IONE, cosv < 0 ? -cosv : cosv);
    f2b = qfs_pkg::add(t, -qfs_pkg::K_HALF);
    u = f2b < 0 ? -f2b : f2b;
    f2a = qfs_pkg::add(u, -f2b);
    f2b = qfs_pkg::add(f2b, u);
    u = qfs_pkg::add(u, u);
    f1 = qfs_pkg::add(qfs_pkg::IONE, -u);
    h = qfs_pkg::add(qfs_pkg::K_A0, -qfs_pkg::mul(
          qfs_pkg::add(qfs_pkg::K_A1, -qfs_pkg::mul(qfs_pkg::K_A2, halfy)), halfy));
    h = qfs_pkg::mul(h, qfs_pkg::add(qfs_pkg::K_THREEHALF,
          -qfs_pkg::mul(qfs_pkg::mul(halfy, h), h)));
    vers = qfs_pkg::add(qfs_pkg::IONE, -qfs_pkg::mul(halfy, h));
    c = qfs_pkg::mul(qfs_pkg::K_S0, vers);
    r1 = weight(qfs_pkg::mul(f1, f1), c, vers);
    r2 = weight(qfs_pkg::mul(u, u), c, vers);
    f1 = qfs_pkg::mul(f1, qfs_pkg::mul(r1, h));
    f2a = qfs_pkg::mul(f2a, r2);
    f2b = qfs_pkg::mul(f2b, r2);
    al = qfs_pkg::add(f1, f2a);
    if (cosv < 0) al = -al;
    be = qfs_pkg::add(f1, f2b);
    len = 0;
    for (int i = 0; i < 4; i++) begin
      r[i] = qfs_pkg::add(qfs_pkg::mul(al, a[i]), qfs_pkg::mul(be, b[i]));
      len = qfs_pkg::add(len, qfs_pkg::mul(r[i], r[i]));
    end
    corr = qfs_pkg::add(qfs_pkg::K_THREEHALF, -qfs_pkg::mul(qfs_pkg::K_HALF, len));
    q.x = to_comp(qfs_pkg::mul(r[0], corr));
    q.y = to_comp(qfs_pkg::mul(r[1], corr));
    q.z = to_comp(qfs_pkg::mul(r[2], corr));
    q.w = to_comp(qfs_pkg::mul(r[3], corr));
    return q;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // Result checker with random bursts of output stalls.
  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[4*CW-1:0];
        if (expected_q.size() == 0) begin
          report("unexpected word", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.x !== want.x) report("x", got.x, want.x);
          if (got.y !== want.y) report("y", got.y, want.y);
          if (got.z !== want.z) report("z", got.z, want.z);
          if (got.w !== want.w) report("w", got.w, want.w);
        end
      end
      if (out_hold > 0) begin
        m_axis_tready <= 0;
        out_hold <= out_hold - 1;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        out_hold <= $urandom_range(0, 12);
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  task automatic send(input pair_t p);
    int gap;
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= IN_W'(p);
    expected_q.push_back(slerp(p));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic comp_t rnd_comp();
    case ($urandom_range(0, 3))
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(0, 65536));
      2: return -comp_t'($urandom_range(0, 65536));
      default: return comp_t'($urandom_range(0, 80000) - 40000);
    endcase
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    p.fx = rnd_comp(); p.fy = rnd_comp(); p.fz = rnd_comp(); p.fw = rnd_comp();
    p.sx = rnd_comp(); p.sy = rnd_comp(); p.sz = rnd_comp(); p.sw = rnd_comp();
    p.blend = 17'($urandom_range(1, 65535));
    case ($urandom_range(0, 9))
      0: p.blend = 0;
      1: p.blend = 17'h10000;
      2: p.blend = 17'($urandom_range(65536, 131071));
      3: {p.sx, p.sy, p.sz, p.sw} = {p.fx, p.fy, p.fz, p.fw};
      default: ;
    endcase
    if (p.blend == 0 && $urandom_range(0, 1)) p.blend = 17'($urandom_range(1, 65535));
    return p;
  endfunction

  task automatic test_corners();
    comp_t ext[4] = '{18'sh1ffff, -18'sh20000, 18'sh10000, -18'sh10000};
    pair_t p;
    logic [FB:0] blends[6] = '{0, 1, 17'h8000, 17'hffff, 17'h10000, 17'h1ffff};
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 5; k++) begin
        p.fx = ext[i]; p.fy = ext[(i+1)%4]; p.fz = 0; p.fw = ext[(i+2)%4];
        p.sx = -ext[(i+3)%4]; p.sy = 0; p.sz = ext[i]; p.sw = ext[(i+1)%4];
        p.blend = blends[(i + k) % 6];
        send(p);
      end
    end
    // zero dot product, then equal inputs
    p = '{blend: 17'h4000, sw: 0, sz: 0, sy: 18'sh10000, sx: 0,
          fw: 18'sh10000, fz: 0, fy: 0, fx: 0};
    send(p);
    p.sw = p.fw; p.sz = p.fz; p.sy = p.fy; p.sx = p.fx;
    send(p);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send(rnd_pair());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_corners();
    test_random(650);
    no_gaps = 1;
    test_random(150);
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
